// File: design/ssn_pkg.sv
// Shared constants for the sphere surface normal pipeline.
`default_nettype none
package ssn_pkg;
	// fixed field widths
	localparam int NORM_W  = 16;
	localparam int SCALE_W = 16;
	// quotient bits resolved by the divide chain
	localparam int QBITS   = 16;
	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
	// saturation limits
	localparam logic [NORM_W-1:0] NORM_MAX = 16'h7fff;
	localparam logic [NORM_W-1:0] NORM_MIN = 16'h8000;
endpackage
`default_nettype wire

// File: design/ssn_sqrt_cell.sv
// One root bit of the digit-by-digit square root chain.
`default_nettype none
module ssn_sqrt_cell #(
	parameter int K      = 25,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_i,
	input  wire logic [2*K-1:0]    rad_i,
	input  wire logic [K+2:0]      rem_i,
	input  wire logic [K-1:0]      root_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   valid_o,
	output logic [2*K-1:0]         rad_o,
	output logic [K+2:0]           rem_o,
	output logic [K-1:0]           root_o,
	output logic [SIDE_W-1:0]      side_o
);
	localparam int RW = K + 3;

	logic [RW-1:0] cur;
	logic [RW-1:0] trial;
	logic          ge;

	// bring down the next two radicand bits and try a one
	always_comb begin
		cur   = {rem_i[RW-3:0], rad_i[2*K-1 -: 2]};
		trial = RW'({root_i, 2'b01});
		ge    = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i << 2;
			rem_o  <= ge ? cur - trial : cur;
			root_o <= {root_i[K-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

// File: design/ssn_div_cell.sv
// One quotient bit for all three components of the divide chain.
`default_nettype none
module ssn_div_cell #(
	parameter int NW     = 40,
	parameter int LW     = 25,
	parameter int BIT    = 15,
	parameter int SIDE_W = 7
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid_i,
	input  wire logic [3*NW-1:0]          rem_i,
	input  wire logic [3*ssn_pkg::QBITS-1:0] q_i,
	input  wire logic [LW-1:0]            len_i,
	input  wire logic [SIDE_W-1:0]        side_i,
	output logic                          valid_o,
	output logic [3*NW-1:0]               rem_o,
	output logic [3*ssn_pkg::QBITS-1:0]   q_o,
	output logic [LW-1:0]                 len_o,
	output logic [SIDE_W-1:0]             side_o
);
	import ssn_pkg::*;

	logic [NW-1:0]       dsh;
	logic [3*NW-1:0]     rem_n;
	logic [3*QBITS-1:0]  q_n;

	// shifted divisor compared against each remainder
	always_comb begin
		dsh   = NW'(len_i) << BIT;
		rem_n = rem_i;
		q_n   = q_i;
		for (int c = 0; c < 3; c++) begin
			if (rem_i[c*NW +: NW] >= dsh) begin
				rem_n[c*NW +: NW]     = rem_i[c*NW +: NW] - dsh;
				q_n[c*QBITS + BIT]    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= rem_n;
			q_o    <= q_n;
			len_o  <= len_i;
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

// File: design/sphere_surface_normal.sv
// Top level: scaled outward sphere normal, offset, square, root and divide pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | in_valid / in_ready  | pos_x, pos_y, pos_z, scale
//  output   | out_valid / out_ready| norm_x, norm_y, norm_z, at_center
//  config   | cfg_we               | cfg_idx, cfg_wdata
//
// One request accepted per cycle unless stalled; stages: offset, square, sum, a root
// cell per root bit, numerator, overflow, a divide cell per quotient bit, output.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the stage valid bits and the center registers.
// A stalled output holds every stage, so in_ready follows out_ready.
`default_nettype none
module sphere_surface_normal #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ssn_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [COORD_BITS-1:0]         cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [COORD_BITS-1:0]         pos_x,
	input  wire logic [COORD_BITS-1:0]         pos_y,
	input  wire logic [COORD_BITS-1:0]         pos_z,
	input  wire logic signed [ssn_pkg::SCALE_W-1:0] scale,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [ssn_pkg::NORM_W-1:0]  norm_x,
	output logic signed [ssn_pkg::NORM_W-1:0]  norm_y,
	output logic signed [ssn_pkg::NORM_W-1:0]  norm_z,
	output logic                               at_center
);
	import ssn_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int K      = CB + 1;
	localparam int RADW   = 2 * K;
	localparam int RW     = K + 3;
	localparam int NW     = CB + SCALE_W;
	localparam int SQ_SW  = 3 * CB + SCALE_W + 4;
	localparam int DV_SW  = 7;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// center registers
	logic [CB-1:0] cen_q [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) cen_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER_X: cen_q[0] <= cfg_wdata;
				REG_CENTER_Y: cen_q[1] <= cfg_wdata;
				REG_CENTER_Z: cen_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: offset magnitudes and signs
	logic                 v_s1;
	logic [CB-1:0]        mag_s1 [3];
	logic [2:0]           negx_s1;
	logic [SCALE_W-1:0]   smag_s1;
	logic [CB-1:0]        pos [3];
	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i]  <= (pos[i] < cen_q[i]) ? cen_q[i] - pos[i] : pos[i] - cen_q[i];
				negx_s1[i] <= (pos[i] < cen_q[i]) ^ scale[SCALE_W-1];
			end
			smag_s1 <= scale[SCALE_W-1] ? SCALE_W'(~scale + 1'b1) : SCALE_W'(scale);
		end
	end

	// stage 2: squares
	logic                 v_s2;
	logic [2*CB-1:0]      sq_s2 [3];
	logic [CB-1:0]        mag_s2 [3];
	logic [2:0]           negx_s2;
	logic [SCALE_W-1:0]   smag_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
				mag_s2[i] <= mag_s1[i];
			end
			negx_s2 <= negx_s1;
			smag_s2 <= smag_s1;
		end
	end

	// stage 3: squared length and center test
	logic                 v_s3;
	logic [RADW-1:0]      sum_s3;
	logic [SQ_SW-1:0]     side_s3;
	logic [RADW-1:0]      sum_n;
	assign sum_n = RADW'(sq_s2[0]) + RADW'(sq_s2[1]) + RADW'(sq_s2[2]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_n;
			side_s3 <= {mag_s2[2], mag_s2[1], mag_s2[0], smag_s2, negx_s2, sum_n == '0};
		end
	end

	// square root chain, one cell per root bit
	logic            sq_v    [K+1];
	logic [RADW-1:0] sq_rad  [K+1];
	logic [RW-1:0]   sq_rem  [K+1];
	logic [K-1:0]    sq_root [K+1];
	logic [SQ_SW-1:0] sq_side [K+1];
	assign sq_v[0]    = v_s3;
	assign sq_rad[0]  = sum_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s3;

	for (genvar g = 0; g < K; g++) begin : g_sqrt
		ssn_sqrt_cell #(.K(K), .SIDE_W(SQ_SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(sq_v[g]), .rad_i(sq_rad[g]), .rem_i(sq_rem[g]),
			.root_i(sq_root[g]), .side_i(sq_side[g]),
			.valid_o(sq_v[g+1]), .rad_o(sq_rad[g+1]), .rem_o(sq_rem[g+1]),
			.root_o(sq_root[g+1]), .side_o(sq_side[g+1])
		);
	end

	// stage 4: numerators
	logic               v_s4;
	logic [NW-1:0]      num_s4 [3];
	logic [K-1:0]       len_s4;
	logic [2:0]         negx_s4;
	logic               zero_s4;
	logic [SQ_SW-1:0]   sqo;
	assign sqo = sq_side[K];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sq_v[K];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= NW'(sqo[SCALE_W + 4 + i*CB +: CB]) * NW'(sqo[4 +: SCALE_W]);
			end
			negx_s4 <= sqo[3:1];
			zero_s4 <= sqo[0];
			len_s4  <= sq_root[K];
		end
	end

	// stage 5: quotient overflow test
	logic               v_s5;
	logic [3*NW-1:0]    num_s5;
	logic [K-1:0]       len_s5;
	logic [DV_SW-1:0]   side_s5;
	logic [2:0]         sat_n;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat_n[i] = (NW+1)'(num_s4[i]) >= ((NW+1)'(len_s4) << QBITS);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s5  <= {num_s4[2], num_s4[1], num_s4[0]};
			len_s5  <= len_s4;
			side_s5 <= {negx_s4, sat_n, zero_s4};
		end
	end

	// divide chain, one cell per quotient bit
	logic               dv_v    [QBITS+1];
	logic [3*NW-1:0]    dv_rem  [QBITS+1];
	logic [3*QBITS-1:0] dv_q    [QBITS+1];
	logic [K-1:0]       dv_len  [QBITS+1];
	logic [DV_SW-1:0]   dv_side [QBITS+1];
	assign dv_v[0]    = v_s5;
	assign dv_rem[0]  = num_s5;
	assign dv_q[0]    = '0;
	assign dv_len[0]  = len_s5;
	assign dv_side[0] = side_s5;

	for (genvar g = 0; g < QBITS; g++) begin : g_div
		ssn_div_cell #(.NW(NW), .LW(K), .BIT(QBITS-1-g), .SIDE_W(DV_SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(dv_v[g]), .rem_i(dv_rem[g]), .q_i(dv_q[g]),
			.len_i(dv_len[g]), .side_i(dv_side[g]),
			.valid_o(dv_v[g+1]), .rem_o(dv_rem[g+1]), .q_o(dv_q[g+1]),
			.len_o(dv_len[g+1]), .side_o(dv_side[g+1])
		);
	end

	// output stage: sign, saturation, center override
	logic [NORM_W-1:0] res_n [3];
	logic [QBITS-1:0]  qv;
	logic              sat, neg, zero;
	always_comb begin
		zero = dv_side[QBITS][0];
		for (int i = 0; i < 3; i++) begin
			qv  = dv_q[QBITS][i*QBITS +: QBITS];
			sat = dv_side[QBITS][1+i];
			neg = dv_side[QBITS][4+i] && (sat || qv != '0);
			if (zero) begin
				res_n[i] = '0;
			end else if (neg) begin
				res_n[i] = (sat || qv > NORM_MIN) ? NORM_MIN : NORM_W'(~qv + 1'b1);
			end else begin
				res_n[i] = (sat || qv > NORM_MAX) ? NORM_MAX : NORM_W'(qv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v[QBITS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			norm_x    <= res_n[0];
			norm_y    <= res_n[1];
			norm_z    <= res_n[2];
			at_center <= zero;
		end
	end
endmodule
`default_nettype wire

// File: design/ssn_check.sv
// Port-level checks for the sphere surface normal block, bound to the top level.
`default_nettype none
module ssn_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [ssn_pkg::NORM_W-1:0] norm_x,
	input wire logic signed [ssn_pkg::NORM_W-1:0] norm_y,
	input wire logic signed [ssn_pkg::NORM_W-1:0] norm_z,
	input wire logic at_center
);
	// result request holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before acceptance");

	// stalled result payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(norm_x) && $stable(norm_y)
			&& $stable(norm_z) && $stable(at_center))
		else $error("output payload changed while stalled");

	// pipeline takes requests whenever the output slot frees
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output slot");

	// center case gives a zero vector
	a_center_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_center |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
		else $error("at_center with nonzero normal");
endmodule

bind sphere_surface_normal ssn_check u_ssn_check (.*);
`default_nettype wire

// File: sim/tb_sphere_surface_normal.sv
// Testbench for sphere_surface_normal: random and directed normal requests, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module tb_sphere_surface_normal;
	import ssn_pkg::*;

	localparam int CW = 24;
	localparam int LATENCY = CW + 23;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               ctr;
	} normal_t;

	// expected normals, computed when a request is accepted
	class normal_scoreboard;
		logic [CW-1:0] center [3];
		normal_t pending [$];
		int errors;

		function new();
			center[0] = '0; center[1] = '0; center[2] = '0;
			errors = 0;
		endfunction

		function automatic logic [15:0] scaled_comp(logic [CW:0] mag, logic dneg,
				logic [16:0] smag, logic sneg, logic [33:0] len);
			logic [63:0] q;
			q = ({39'd0, mag} * {47'd0, smag}) / {30'd0, len};
			if (dneg != sneg && q != 0) begin
				if (q > 64'd32768) q = 64'd32768;
				return 16'(-q);
			end
			if (q > 64'd32767) q = 64'd32767;
			return q[15:0];
		endfunction

		function void note_request(logic [CW-1:0] p [3], logic signed [15:0] s);
			logic [CW:0] mag [3];
			logic dneg [3];
			logic [67:0] l2;
			logic [33:0] len, c;
			logic [16:0] smag;
			logic sneg;
			normal_t e;
			logic [15:0] r [3];
			l2 = 0;
			for (int i = 0; i < 3; i++) begin
				dneg[i] = p[i] < center[i];
				mag[i] = dneg[i] ? center[i] - p[i] : p[i] - center[i];
				l2 += {43'd0, mag[i]} * {43'd0, mag[i]};
			end
			if (l2 == 0) begin
				e = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
			end else begin
				// floor square root, bit by bit
				len = 0;
				for (int b = 33; b >= 0; b--) begin
					c = len | (34'd1 << b);
					if ({34'd0, c} * {34'd0, c} <= l2) len = c;
				end
				sneg = s[15];
				smag = sneg ? 17'h10000 - {1'b0, s} : {1'b0, s};
				for (int i = 0; i < 3; i++) r[i] = scaled_comp(mag[i], dneg[i], smag, sneg, len);
				e = '{r[0], r[1], r[2], 1'b0};
			end
			pending.push_back(e);
		endfunction

		function void check_result(normal_t got);
			normal_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.nx !== e.nx) begin
				$error("norm_x expected %0d got %0d", e.nx, got.nx); errors++;
			end
			if (got.ny !== e.ny) begin
				$error("norm_y expected %0d got %0d", e.ny, got.ny); errors++;
			end
			if (got.nz !== e.nz) begin
				$error("norm_z expected %0d got %0d", e.nz, got.nz); errors++;
			end
			if (got.ctr !== e.ctr) begin
				$error("at_center expected %0d got %0d", e.ctr, got.ctr); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CW-1:0] cfg_wdata = '0;
	logic in_valid = 0, in_ready;
	logic [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] scale = '0;
	logic out_valid, out_ready = 0;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic at_center;

	normal_scoreboard sb = new();
	int cycles = 0;
	bit hold_off = 0;
	bit drain = 0;

	sphere_surface_normal uut (.*);

	always #5 clk = ~clk;

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: sample and check at the rising edge
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result('{norm_x, norm_y, norm_z, at_center});

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) out_ready <= 0;
			else if (drain) out_ready <= 1;
			else begin
				k = (k + 1) % 64;
				out_ready <= (k < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.center[idx] = v;
	endtask

	task automatic set_center(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_CENTER_Z, z);
	endtask

	// offer one request; leaves valid high on return, the caller lowers it when none follows
	task automatic send_request(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
			logic signed [15:0] s);
		logic [CW-1:0] p [3];
		pos_x <= x; pos_y <= y; pos_z <= z; scale <= s;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		p[0] = x; p[1] = y; p[2] = z;
		sb.note_request(p, s);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		in_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_empty();
		in_valid <= 0;
		drain = 1;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		drain = 0;
	endtask

	function automatic logic [CW-1:0] near(logic [CW-1:0] c, int span);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0) v = 0;
		if (v > 24'hffffff) v = 24'hffffff;
		return v[CW-1:0];
	endfunction

	task automatic random_burst(int n, int span);
		logic [CW-1:0] c [3];
		logic signed [15:0] s;
		c = sb.center;
		for (int i = 0; i < n; i++) begin
			s = 16'($urandom);
			if ($urandom_range(0, 5) == 0) s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			if ($urandom_range(0, 30) == 0)
				send_request(c[0], c[1], c[2], s);
			else if (span == 0)
				send_request(CW'($urandom), CW'($urandom), CW'($urandom), s);
			else
				send_request(near(c[0], span), near(c[1], span), near(c[2], span), s);
			if ($urandom_range(0, 4) == 0) idle_gap(int'($urandom_range(1, 6)));
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: center at reset value, axis extremes, both scale extremes
		send_request(0, 0, 0, 16'sh4000);
		send_request(24'hffffff, 0, 0, 16'sh7fff);
		send_request(0, 24'hffffff, 0, 16'sh8000);
		send_request(0, 0, 24'hffffff, -16'sd1);
		send_request(24'hffffff, 24'hffffff, 24'hffffff, 16'sh7fff);
		send_request(24'hffffff, 24'hffffff, 24'hffffff, 16'sh8000);
		send_request(1, 1, 1, 16'sh7fff);
		send_request(3, 4, 0, 16'sh0000);
		wait_empty();
		set_center(24'hffffff, 24'hffffff, 24'hffffff);
		send_request(24'hffffff, 24'hffffff, 24'hffffff, 16'sh7fff);
		send_request(0, 0, 0, 16'sh7fff);
		send_request(0, 0, 0, 16'sh8000);
		send_request(24'hfffffe, 24'hffffff, 24'hffffff, 16'sh8000);
		send_request(24'hfffffe, 24'hfffffe, 24'hffffff, 16'sh7fff);
		wait_empty();
		set_center(24'h800000, 24'h123456, 24'h000001);
		send_request(24'h800000, 24'h123456, 24'h000001, 16'sh8000);
		send_request(24'h800001, 24'h123457, 24'h000000, 16'sh7fff);
		send_request(24'h7fffff, 24'h123456, 24'h000001, 16'sh8000);
		wait_empty();

		// random phases, several centers; near-center and far offsets
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_center(0, 0, 0);
				1: set_center(24'hffffff, 24'hffffff, 24'hffffff);
				default: set_center(CW'($urandom), CW'($urandom), CW'($urandom));
			endcase
			random_burst(60, 0);
			random_burst(50, 3);
			random_burst(35, 300);
			if (ph == 2) begin
				// long receiver hold-off while requests keep coming
				fork
					begin
						hold_off = 1;
						repeat (LATENCY * 3) @(negedge clk);
						hold_off = 0;
					end
					random_burst(40, 0);
				join
			end
			wait_empty();
		end

		wait_empty();
		repeat (LATENCY + 10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
design/ssn_pkg.sv
design/ssn_sqrt_cell.sv
design/ssn_div_cell.sv
design/sphere_surface_normal.sv
design/ssn_check.sv
sim/tb_sphere_surface_normal.sv
